/* design/csc_pkg.sv */
package csc_pkg;

  typedef enum logic {
    OpEncode = 1'b0,
    OpDecode = 1'b1
  } op_e;

  localparam int unsigned NumStages = 6;

  localparam int unsigned SecsPerDay = 86400;
  localparam int unsigned SecsPerHour = 3600;
  localparam int unsigned SecsPerMin = 60;
  localparam int unsigned DaysPerYear = 365;
  localparam int unsigned DaysPerCycle = 1461;
  localparam int unsigned MaxYear = 99;

  // floor(x / d) = (x * recip) >> shift, exact over the value range used
  localparam logic [25:0] DayRecip = 26'd50903317;
  localparam int unsigned DayShift = 35;
  localparam logic [15:0] CycleRecip = 16'd45934;
  localparam int unsigned CycleShift = 26;
  localparam logic [17:0] MinRecip = 18'd139811;
  localparam int unsigned MinShift = 23;
  localparam logic [10:0] HourRecip = 11'd1093;
  localparam int unsigned HourShift = 16;

  // day count of 2100-03-01, where the missing leap day of 2100 is skipped
  localparam logic [15:0] Mar2100Day = 16'd36584;

  localparam logic [10:0] Year1Start = 11'd366;
  localparam logic [10:0] Year2Start = 11'd731;
  localparam logic [10:0] Year3Start = 11'd1096;

  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] r;
    unique case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] r;
    unique case (m)
      4'd2:                      r = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
      default:                   r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

/* design/calendar_seconds_converter.sv */
// calendar_seconds_converter: date fields <-> seconds since 2000-01-01 00:00:00
// a request passes through a six stage pipeline to its result
// throughput: one request per cycle while out_stall_i is low; each stage holds while the stage after it is full
// and stalled, so bubbles are squeezed out before the input is stalled
// reset: rst_ni is asynchronous active low and clears only the stage valid bits
module calendar_seconds_converter
  import csc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [7:0]  year_in_i,
  input  logic [7:0]  month_in_i,
  input  logic [7:0]  day_in_i,
  input  logic [7:0]  hour_in_i,
  input  logic [7:0]  minute_in_i,
  input  logic [7:0]  second_in_i,
  input  logic [31:0] seconds_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] seconds_out_o,
  output logic [7:0]  year_out_o,
  output logic [3:0]  month_out_o,
  output logic [4:0]  day_out_o,
  output logic [4:0]  hour_out_o,
  output logic [5:0]  minute_out_o,
  output logic [5:0]  second_out_o,
  output logic        valid_res_o
);

  logic [NumStages:1] v_q, v_d, en;
  op_e                op_q [NumStages-1:1];

  // pipeline control
  always_comb begin
    en[NumStages] = !v_q[NumStages] || !out_stall_i;
    for (int k = NumStages - 1; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d[1] = en[1] ? in_valid_i : v_q[1];
    for (int k = 2; k <= NumStages; k++) begin
      v_d[k] = en[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_stall_o  = !en[1];
  assign out_valid_o = v_q[NumStages];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      op_q[1] <= op_e'(op_i);
    end
    for (int k = 2; k <= NumStages - 1; k++) begin
      if (en[k]) begin
        op_q[k] <= op_q[k-1];
      end
    end
  end

  // encode stage 1: field check
  logic       e1_ok_d, e1_ok_q, e1_leap_d, e1_leap_q;
  logic [4:0] e1_mlen;
  logic [6:0] e1_year_q;
  logic [3:0] e1_month_q;
  logic [4:0] e1_day_q, e1_hour_q;
  logic [5:0] e1_min_q, e1_sec_q;

  always_comb begin
    e1_leap_d = (year_in_i[1:0] == 2'b00);
    e1_mlen   = month_len(month_in_i[3:0])
              + 5'((month_in_i == 8'd2) && e1_leap_d);
    e1_ok_d   = (second_in_i < 8'(SecsPerMin)) && (minute_in_i < 8'(SecsPerMin))
             && (hour_in_i < 8'd24) && (month_in_i >= 8'd1) && (month_in_i <= 8'd12)
             && (year_in_i <= 8'(MaxYear)) && (day_in_i >= 8'd1)
             && (day_in_i <= 8'(e1_mlen));
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      e1_ok_q    <= e1_ok_d;
      e1_leap_q  <= e1_leap_d;
      e1_year_q  <= year_in_i[6:0];
      e1_month_q <= month_in_i[3:0];
      e1_day_q   <= day_in_i[4:0];
      e1_hour_q  <= hour_in_i[4:0];
      e1_min_q   <= minute_in_i[5:0];
      e1_sec_q   <= second_in_i[5:0];
    end
  end

  // encode stage 2: day count and time of day
  logic [15:0] e2_days_d, e2_days_q;
  logic [16:0] e2_tod_d, e2_tod_q;
  logic        e2_ok_q;

  always_comb begin
    e2_days_d = 16'(e1_year_q) * 16'(DaysPerYear)
              + 16'((8'(e1_year_q) + 8'd3) >> 2)
              + 16'(cum_days(e1_month_q))
              + 16'(e1_leap_q && (e1_month_q > 4'd2))
              + 16'(e1_day_q) - 16'd1;
    e2_tod_d  = 17'(e1_hour_q) * 17'(SecsPerHour)
              + 17'(e1_min_q) * 17'(SecsPerMin)
              + 17'(e1_sec_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      e2_days_q <= e2_days_d;
      e2_tod_q  <= e2_tod_d;
      e2_ok_q   <= e1_ok_q;
    end
  end

  // encode stage 3 and delay line
  logic [31:0] e_secs_q [NumStages-1:3];
  logic        e_ok_q   [NumStages-1:3];

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      e_secs_q[3] <= 32'(e2_days_q) * 32'(SecsPerDay) + 32'(e2_tod_q);
      e_ok_q[3]   <= e2_ok_q;
    end
    for (int k = 4; k <= NumStages - 1; k++) begin
      if (en[k]) begin
        e_secs_q[k] <= e_secs_q[k-1];
        e_ok_q[k]   <= e_ok_q[k-1];
      end
    end
  end

  // decode stage 1: days = seconds / 86400
  logic [50:0] d1_prod;
  logic [15:0] d1_days_q;
  logic [31:0] d1_secs_q;

  assign d1_prod = 51'(seconds_in_i[31:7]) * 51'(DayRecip);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      d1_days_q <= d1_prod[DayShift+15:DayShift];
      d1_secs_q <= seconds_in_i;
    end
  end

  // decode stage 2: second of day, skip the leap day that 2100 lacks
  logic [31:0] d2_rem_full;
  logic [16:0] d2_rem_q;
  logic [15:0] d2_dadj_q;

  assign d2_rem_full = d1_secs_q - 32'(d1_days_q) * 32'(SecsPerDay);

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      d2_rem_q  <= d2_rem_full[16:0];
      d2_dadj_q <= d1_days_q + 16'(d1_days_q >= Mar2100Day);
    end
  end

  // decode stage 3: four-year cycles and minute of day
  logic [31:0] d3_cyc_prod;
  logic [34:0] d3_min_prod;
  logic [5:0]  d3_cyc_q;
  logic [10:0] d3_mt_q;
  logic [15:0] d3_dadj_q;
  logic [16:0] d3_rem_q;

  assign d3_cyc_prod = 32'(d2_dadj_q) * 32'(CycleRecip);
  assign d3_min_prod = 35'(d2_rem_q) * 35'(MinRecip);

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      d3_cyc_q  <= d3_cyc_prod[CycleShift+5:CycleShift];
      d3_mt_q   <= d3_min_prod[MinShift+10:MinShift];
      d3_dadj_q <= d2_dadj_q;
      d3_rem_q  <= d2_rem_q;
    end
  end

  // decode stage 4: day of cycle, second, hour
  logic [15:0] d4_r4_full;
  logic [16:0] d4_sec_full;
  logic [21:0] d4_hour_prod;
  logic [10:0] d4_r4_q, d4_mt_q;
  logic [5:0]  d4_sec_q, d4_cyc_q;
  logic [4:0]  d4_hour_q;

  assign d4_r4_full   = d3_dadj_q - 16'(d3_cyc_q) * 16'(DaysPerCycle);
  assign d4_sec_full  = d3_rem_q - 17'(d3_mt_q) * 17'(SecsPerMin);
  assign d4_hour_prod = 22'(d3_mt_q) * 22'(HourRecip);

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      d4_r4_q   <= d4_r4_full[10:0];
      d4_sec_q  <= d4_sec_full[5:0];
      d4_hour_q <= d4_hour_prod[HourShift+4:HourShift];
      d4_mt_q   <= d3_mt_q;
      d4_cyc_q  <= d3_cyc_q;
    end
  end

  // decode stage 5: year within cycle, day of year, minute
  logic [1:0]  d5_k;
  logic [10:0] d5_start;
  logic [10:0] d5_min_full;
  logic [8:0]  d5_doy_q;
  logic [7:0]  d5_year_q;
  logic        d5_leap_q;
  logic [4:0]  d5_hour_q;
  logic [5:0]  d5_min_q, d5_sec_q;

  always_comb begin
    priority if (d4_r4_q >= Year3Start) begin
      d5_k = 2'd3;
      d5_start = Year3Start;
    end else if (d4_r4_q >= Year2Start) begin
      d5_k = 2'd2;
      d5_start = Year2Start;
    end else if (d4_r4_q >= Year1Start) begin
      d5_k = 2'd1;
      d5_start = Year1Start;
    end else begin
      d5_k = 2'd0;
      d5_start = 11'd0;
    end
    d5_min_full = d4_mt_q - 11'(d4_hour_q) * 11'(SecsPerMin);
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      d5_doy_q  <= 9'(d4_r4_q - d5_start);
      d5_year_q <= {d4_cyc_q, d5_k};
      d5_leap_q <= (d5_k == 2'd0);
      d5_hour_q <= d4_hour_q;
      d5_min_q  <= d5_min_full[5:0];
      d5_sec_q  <= d4_sec_q;
    end
  end

  // decode stage 6: month and day, then select result by op
  logic [3:0]  d6_month;
  logic [8:0]  d6_mstart;
  logic [8:0]  d6_day_full;

  always_comb begin
    d6_month = 4'd1;
    for (int m = 2; m <= 12; m++) begin
      if (d5_doy_q >= cum_days(4'(m)) + 9'(d5_leap_q && (m > 2))) begin
        d6_month = d6_month + 4'd1;
      end
    end
    d6_mstart   = cum_days(d6_month) + 9'(d5_leap_q && (d6_month > 4'd2));
    d6_day_full = d5_doy_q - d6_mstart + 9'd1;
  end

  always_ff @(posedge clk_i) begin
    if (en[NumStages]) begin
      if (op_q[NumStages-1] == OpEncode) begin
        seconds_out_o <= e_ok_q[NumStages-1] ? e_secs_q[NumStages-1] : '0;
        year_out_o    <= '0;
        month_out_o   <= '0;
        day_out_o     <= '0;
        hour_out_o    <= '0;
        minute_out_o  <= '0;
        second_out_o  <= '0;
        valid_res_o   <= e_ok_q[NumStages-1];
      end else begin
        seconds_out_o <= '0;
        year_out_o    <= d5_year_q;
        month_out_o   <= d6_month;
        day_out_o     <= d6_day_full[4:0];
        hour_out_o    <= d5_hour_q;
        minute_out_o  <= d5_min_q;
        second_out_o  <= d5_sec_q;
        valid_res_o   <= (d5_year_q <= 8'(MaxYear));
      end
    end
  end

endmodule

/* verif/tb_top.sv */
module tb_top
  import csc_pkg::*;
();

  localparam int Period = 12;
  localparam int ResetCycles = 4;
  localparam int HoldCycles = 200;
  localparam int DrainCycles = NumStages + 6;
  localparam int LimitCycles = 400000;

  typedef struct packed {
    op_e         op;
    logic [7:0]  year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
    logic [31:0] seconds;
  } calendar_req_t;

  typedef struct packed {
    logic [31:0] seconds;
    logic [7:0]  year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        valid;
  } calendar_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        op_i = OpEncode;
  logic [7:0]  year_in_i = '0;
  logic [7:0]  month_in_i = '0;
  logic [7:0]  day_in_i = '0;
  logic [7:0]  hour_in_i = '0;
  logic [7:0]  minute_in_i = '0;
  logic [7:0]  second_in_i = '0;
  logic [31:0] seconds_in_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] seconds_out_o;
  logic [7:0]  year_out_o;
  logic [3:0]  month_out_o;
  logic [4:0]  day_out_o;
  logic [4:0]  hour_out_o;
  logic [5:0]  minute_out_o;
  logic [5:0]  second_out_o;
  logic        valid_res_o;

  calendar_res_t conversions_due[$];
  int unsigned   mismatch_count = 0;
  int unsigned   idle_pct = 0;
  int unsigned   stall_pct = 0;
  bit            hold_pending = 1'b0;

  calendar_seconds_converter u_dut (.*);

  always #(Period / 2) clk_i = ~clk_i;

  function automatic bit is_leap(input int unsigned y);
    int unsigned full;
    full = y + 2000;
    return ((full % 4 == 0) && (full % 100 != 0)) || (full % 400 == 0);
  endfunction

  function automatic int unsigned year_length(input int unsigned y);
    return is_leap(y) ? 366 : 365;
  endfunction

  function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
    case (m)
      2:             return is_leap(y) ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  function automatic int unsigned days_before_year(input int unsigned y);
    int unsigned total;
    total = 0;
    for (int unsigned i = 0; i < y; i++) total += year_length(i);
    return total;
  endfunction

  function automatic calendar_res_t convert_calendar(input calendar_req_t r);
    calendar_res_t res;
    int unsigned   days;
    int unsigned   rem;
    int unsigned   y;
    int unsigned   m;
    res = '0;
    if (r.op == OpEncode) begin
      y = 32'(r.year);
      if (r.second < 60 && r.minute < 60 && r.hour < 24 && r.month >= 1 && r.month <= 12
          && y <= MaxYear && r.day >= 1 && r.day <= month_length(y, 32'(r.month))) begin
        days = days_before_year(y);
        for (m = 1; m < r.month; m++) days += month_length(y, m);
        days += 32'(r.day) - 1;
        res.seconds = ((days * 24 + 32'(r.hour)) * 60 + 32'(r.minute)) * 60
                    + 32'(r.second);
        res.valid = 1'b1;
      end
    end else begin
      days = r.seconds / SecsPerDay;
      rem = r.seconds % SecsPerDay;
      y = 0;
      while (days >= year_length(y)) begin
        days -= year_length(y);
        y++;
      end
      m = 1;
      while (m < 12 && days >= month_length(y, m)) begin
        days -= month_length(y, m);
        m++;
      end
      res.year = 8'(y);
      res.month = 4'(m);
      res.day = 5'(days + 1);
      res.hour = 5'(rem / 3600);
      res.minute = 6'((rem % 3600) / 60);
      res.second = 6'(rem % 60);
      res.valid = (y <= MaxYear);
    end
    return res;
  endfunction

  function automatic calendar_req_t encode_req(input int unsigned y, input int unsigned mo,
                                               input int unsigned d, input int unsigned h,
                                               input int unsigned mi, input int unsigned s);
    calendar_req_t r;
    r.op = OpEncode;
    r.year = 8'(y);
    r.month = 8'(mo);
    r.day = 8'(d);
    r.hour = 8'(h);
    r.minute = 8'(mi);
    r.second = 8'(s);
    r.seconds = $urandom;
    return r;
  endfunction

  function automatic calendar_req_t decode_req(input logic [31:0] secs);
    calendar_req_t r;
    r = encode_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    r.op = OpDecode;
    r.seconds = secs;
    return r;
  endfunction

  function automatic calendar_req_t random_request();
    calendar_req_t r;
    int unsigned   y;
    int unsigned   mo;
    int unsigned   pick;
    pick = $urandom_range(99);
    if ($urandom_range(1) == 0) begin
      if (pick < 70) begin
        y = $urandom_range(MaxYear);
        mo = $urandom_range(12, 1);
        r = encode_req(y, mo, $urandom_range(month_length(y, mo), 1), $urandom_range(23),
                       $urandom_range(59), $urandom_range(59));
      end else begin
        r = encode_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
    end else if (pick < 40) begin
      r = decode_req($urandom);
    end else if (pick < 75) begin
      r = decode_req($urandom_range(32'd3155759999, 0));
    end else begin
      // around a new year, past 2100 too
      y = $urandom_range(136, 1);
      r = decode_req(days_before_year(y) * SecsPerDay - 43200 + $urandom_range(SecsPerDay));
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    end
  endtask

  task automatic send_request(input calendar_req_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= r.op;
    year_in_i <= r.year;
    month_in_i <= r.month;
    day_in_i <= r.day;
    hour_in_i <= r.hour;
    minute_in_i <= r.minute;
    second_in_i <= r.second;
    seconds_in_i <= r.seconds;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    conversions_due.push_back(convert_calendar(r));
  endtask

  // receiver side: random stall, or a counted hold-off on request
  initial begin : stall_driver
    int unsigned held;
    forever begin
      @(posedge clk_i);
      if (hold_pending) begin
        held = 0;
        while (held < HoldCycles) begin
          out_stall_i <= 1'b1;
          @(posedge clk_i);
          held++;
        end
        hold_pending = 1'b0;
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin : result_checker
    calendar_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (conversions_due.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = conversions_due.pop_front();
        check_field("seconds_out", seconds_out_o, want.seconds);
        check_field("year_out", 32'(year_out_o), 32'(want.year));
        check_field("month_out", 32'(month_out_o), 32'(want.month));
        check_field("day_out", 32'(day_out_o), 32'(want.day));
        check_field("hour_out", 32'(hour_out_o), 32'(want.hour));
        check_field("minute_out", 32'(minute_out_o), 32'(want.minute));
        check_field("second_out", 32'(second_out_o), 32'(want.second));
        check_field("valid_res", 32'(valid_res_o), 32'(want.valid));
      end
    end
  end

  task automatic test_encode_limits();
    send_request(encode_req(0, 1, 1, 0, 0, 0));
    send_request(encode_req(99, 12, 31, 23, 59, 59));
    send_request(encode_req(3, 12, 31, 23, 59, 59));
    send_request(encode_req(5, 4, 30, 12, 30, 30));
  endtask

  task automatic test_encode_invalid_fields();
    send_request(encode_req(100, 1, 1, 0, 0, 0));
    send_request(encode_req(255, 255, 255, 255, 255, 255));
    send_request(encode_req(10, 6, 15, 12, 30, 60));
    send_request(encode_req(10, 6, 15, 12, 60, 0));
    send_request(encode_req(10, 6, 15, 24, 0, 0));
    send_request(encode_req(10, 0, 15, 0, 0, 0));
    send_request(encode_req(10, 13, 15, 0, 0, 0));
    send_request(encode_req(10, 6, 0, 0, 0, 0));
    send_request(encode_req(0, 4, 31, 0, 0, 0));
  endtask

  task automatic test_february();
    send_request(encode_req(0, 2, 29, 0, 0, 0));
    send_request(encode_req(1, 2, 29, 0, 0, 0));
    send_request(encode_req(96, 2, 29, 23, 59, 59));
    send_request(encode_req(99, 2, 28, 0, 0, 0));
    send_request(decode_req(59 * SecsPerDay + 43200));
  endtask

  task automatic test_decode_limits();
    send_request(decode_req(32'd0));
    send_request(decode_req(32'd86399));
    send_request(decode_req(32'hffff_ffff));
    send_request(decode_req(32'd3155759999));
    send_request(decode_req(32'd3155760000));
    send_request(decode_req(32'd3160857599));
    send_request(decode_req(32'd3160857600));
  endtask

  task automatic test_random_phase(input int unsigned count, input int unsigned idle,
                                   input int unsigned stall);
    idle_pct = idle;
    stall_pct = stall;
    repeat (count) send_request(random_request());
  endtask

  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    hold_pending = 1'b1;
    repeat (40) send_request(random_request());
    while (hold_pending) @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (conversions_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_encode_limits();
    test_encode_invalid_fields();
    test_february();
    test_decode_limits();
    test_random_phase(500, 0, 0);
    test_random_phase(450, 72, 0);
    test_random_phase(450, 0, 72);
    test_random_phase(450, 6, 6);
    test_backpressure();
    drain_results();
    if (mismatch_count == 0) begin
      $display("calendar_seconds_converter test passed");
    end else begin
      $display("calendar_seconds_converter test failed");
    end
    $finish;
  end

  initial begin : run_limit
    #(Period * LimitCycles);
    $display("calendar_seconds_converter test failed");
    $finish;
  end

endmodule
